FILE: rtl/efsa_pkg.sv
package efsa_pkg;

  // Number of service windows (1 to 16).
  localparam int WINDOWS   = 16;
  localparam int WIN_IDX_W = (WINDOWS > 1) ? $clog2(WINDOWS) : 1;

  // Field widths.
  localparam int TIME_W    = 17;
  localparam int FREE_W    = 24;
  localparam int SUM_W     = 32;
  localparam int CNT_W     = 16;
  localparam int SVC_W     = 10;
  localparam int WIU_W     = 5;
  localparam int HOUR_W    = 5;
  localparam int MIN_W     = 6;
  localparam int SEC_W     = 6;
  localparam int IDX_OUT_W = 4;
  localparam int CFG_IDX_W = 2;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_OPEN_TIME      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_TIME     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOWS_IN_USE = 2'd2;

  // Reset values.
  localparam logic [TIME_W-1:0] RESET_OPEN  = 17'd28800;
  localparam logic [TIME_W-1:0] RESET_CLOSE = 17'd61200;
  localparam logic [WIU_W-1:0]  RESET_WIU   = 5'd16;

  localparam logic [TIME_W-1:0] SEC_PER_HOUR = 17'd3600;
  localparam logic [TIME_W-1:0] SEC_PER_MIN  = 17'd60;

  // Controller to datapath.
  typedef struct packed {
    logic                 take;      // ready toward the request channel
    logic                 rd_en;     // read one window free time
    logic [WIN_IDX_W-1:0] rd_addr;
    logic                 rd_first;  // first window of the scan
    logic                 commit;    // write back and load the result
  } efsa_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic                 refused;   // arrival later than close time
    logic [WIN_IDX_W-1:0] last_idx;  // highest window in use
    logic                 out_busy;  // result register full and stalled
  } efsa_sts_t;

endpackage

FILE: rtl/efsa_if.sv
interface efsa_req_if;
  import efsa_pkg::*;
  logic              valid;
  logic              ready;
  logic              first_of_batch;
  logic [HOUR_W-1:0] arrival_hour;
  logic [MIN_W-1:0]  arrival_minute;
  logic [SEC_W-1:0]  arrival_second;
  logic [SVC_W-1:0]  service_minutes;

  modport source (output valid, first_of_batch, arrival_hour, arrival_minute,
                  arrival_second, service_minutes, input ready);
  modport sink (input valid, first_of_batch, arrival_hour, arrival_minute,
                arrival_second, service_minutes, output ready);
endinterface

interface efsa_rsp_if;
  import efsa_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 served;
  logic [IDX_OUT_W-1:0] window_index;
  logic [FREE_W-1:0]    wait_seconds;
  logic [SUM_W-1:0]     sum_wait;
  logic [CNT_W-1:0]     count_served;

  modport source (output valid, served, window_index, wait_seconds, sum_wait,
                  count_served, input ready);
  modport sink (input valid, served, window_index, wait_seconds, sum_wait,
                count_served, output ready);
endinterface

interface efsa_cfg_if;
  import efsa_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] reg_index;
  logic [TIME_W-1:0]    data;

  modport source (output valid, reg_index, data, input ready);
  modport sink (input valid, reg_index, data, output ready);
endinterface

FILE: rtl/efsa_ram.sv
module efsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/efsa_datapath.sv
module efsa_datapath (
  input  logic               clk,
  input  logic               rst,
  efsa_cfg_if.sink           cfg,
  efsa_req_if.sink           req,
  efsa_rsp_if.source         rsp,
  input  efsa_pkg::efsa_cmd_t cmd,
  output efsa_pkg::efsa_sts_t sts
);
  import efsa_pkg::*;

  // Configuration registers.
  logic [TIME_W-1:0] open_time;
  logic [TIME_W-1:0] close_time;
  logic [WIU_W-1:0]  windows_in_use;

  // Open time latched at the last batch start; unwritten windows read as it.
  logic [TIME_W-1:0]  batch_open;
  logic [WINDOWS-1:0] win_valid;

  logic [TIME_W-1:0] arrival;
  logic [SVC_W-1:0]  service;
  logic [SUM_W-1:0]  wait_sum;
  logic [CNT_W-1:0]  srv_cnt;

  // Scan pipeline: read issued last cycle, compared this cycle.
  logic                 cmp_pend;
  logic                 cmp_first;
  logic [WIN_IDX_W-1:0] cmp_idx;
  logic [FREE_W-1:0]    best;
  logic [WIN_IDX_W-1:0] chosen;

  // Result register.
  logic                 out_valid;
  logic                 rsp_served;
  logic [IDX_OUT_W-1:0] rsp_index;
  logic [FREE_W-1:0]    rsp_wait;
  logic [SUM_W-1:0]     rsp_total_wait;
  logic [CNT_W-1:0]     rsp_total_srv;

  logic                 load;
  logic [TIME_W-1:0]    arr_calc;
  logic [FREE_W-1:0]    ram_q;
  logic [FREE_W-1:0]    cand;
  logic [FREE_W-1:0]    arr_ext;
  logic [FREE_W-1:0]    wait_now;
  logic [FREE_W-1:0]    start_time;
  logic [CNT_W-1:0]     svc_secs;
  logic [FREE_W:0]      free_sum;
  logic [FREE_W-1:0]    free_next;
  logic [SUM_W:0]       wsum_add;
  logic [SUM_W-1:0]     wsum_next;
  logic [CNT_W-1:0]     cnt_next;
  logic [6:0]           wiu_ext;
  logic [WIN_IDX_W-1:0] last_idx;

  assign load      = req.valid && cmd.take;
  assign req.ready = cmd.take;
  assign cfg.ready = 1'b1;

  assign arr_calc = TIME_W'(req.arrival_hour) * SEC_PER_HOUR
                  + TIME_W'(req.arrival_minute) * SEC_PER_MIN
                  + TIME_W'(req.arrival_second);

  assign cand = win_valid[cmp_idx] ? ram_q : FREE_W'(batch_open);

  // Clamp windows in use to 1..WINDOWS.
  assign wiu_ext = 7'(windows_in_use);
  always_comb begin
    priority if (wiu_ext == 7'd0) begin
      last_idx = '0;
    end else if (wiu_ext > 7'(WINDOWS)) begin
      last_idx = WIN_IDX_W'(WINDOWS - 1);
    end else begin
      last_idx = WIN_IDX_W'(wiu_ext - 7'd1);
    end
  end

  assign sts.last_idx = last_idx;
  assign sts.refused  = arrival > close_time;
  assign sts.out_busy = out_valid && !rsp.ready;

  // Wait, new free time and totals for the chosen window.
  assign arr_ext    = FREE_W'(arrival);
  assign wait_now   = (best > arr_ext) ? best - arr_ext : '0;
  assign start_time = (best > arr_ext) ? best : arr_ext;
  assign svc_secs   = CNT_W'(service) * CNT_W'(SEC_PER_MIN);
  assign free_sum   = (FREE_W + 1)'(start_time) + (FREE_W + 1)'(svc_secs);
  assign free_next  = free_sum[FREE_W] ? '1 : free_sum[FREE_W-1:0];
  assign wsum_add   = (SUM_W + 1)'(wait_sum) + (SUM_W + 1)'(wait_now);
  assign wsum_next  = wsum_add[SUM_W] ? '1 : wsum_add[SUM_W-1:0];
  assign cnt_next   = (srv_cnt == '1) ? srv_cnt : srv_cnt + CNT_W'(1);

  efsa_ram #(
    .WIDTH (FREE_W),
    .DEPTH (WINDOWS)
  ) u_free_ram (
    .clk   (clk),
    .we    (cmd.commit && !sts.refused),
    .waddr (chosen),
    .wdata (free_next),
    .re    (cmd.rd_en),
    .raddr (cmd.rd_addr),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      open_time      <= RESET_OPEN;
      close_time     <= RESET_CLOSE;
      windows_in_use <= RESET_WIU;
      batch_open     <= RESET_OPEN;
      win_valid      <= '0;
      wait_sum       <= '0;
      srv_cnt        <= '0;
      cmp_pend       <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg.valid) begin
        unique case (cfg.reg_index)
          CFG_OPEN_TIME:      open_time      <= cfg.data;
          CFG_CLOSE_TIME:     close_time     <= cfg.data;
          CFG_WINDOWS_IN_USE: windows_in_use <= WIU_W'(cfg.data);
          default: ;
        endcase
      end

      cmp_pend  <= cmd.rd_en;
      cmp_idx   <= cmd.rd_addr;
      cmp_first <= cmd.rd_first;

      if (load) begin
        arrival <= arr_calc;
        service <= req.service_minutes;
        if (req.first_of_batch) begin
          batch_open <= open_time;
          win_valid  <= '0;
          wait_sum   <= '0;
          srv_cnt    <= '0;
        end
      end

      if (cmp_pend && (cmp_first || cand < best)) begin
        best   <= cand;
        chosen <= cmp_idx;
      end

      if (cmd.commit) begin
        out_valid <= 1'b1;
        if (sts.refused) begin
          rsp_served     <= 1'b0;
          rsp_index      <= '0;
          rsp_wait       <= '0;
          rsp_total_wait <= wait_sum;
          rsp_total_srv  <= srv_cnt;
        end else begin
          win_valid[chosen] <= 1'b1;
          wait_sum          <= wsum_next;
          srv_cnt           <= cnt_next;
          rsp_served        <= 1'b1;
          rsp_index         <= IDX_OUT_W'(chosen);
          rsp_wait          <= wait_now;
          rsp_total_wait    <= wsum_next;
          rsp_total_srv     <= cnt_next;
        end
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.served       = rsp_served;
  assign rsp.window_index = rsp_index;
  assign rsp.wait_seconds = rsp_wait;
  assign rsp.sum_wait     = rsp_total_wait;
  assign rsp.count_served = rsp_total_srv;

endmodule

FILE: rtl/efsa_ctrl.sv
module efsa_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  input  efsa_pkg::efsa_sts_t sts,
  output efsa_pkg::efsa_cmd_t cmd
);
  import efsa_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } state_t;

  state_t               state;
  logic [WIN_IDX_W-1:0] cnt;

  always_comb begin
    cmd          = '0;
    cmd.take     = (state == S_IDLE);
    unique case (state)
      S_EVAL: begin
        cmd.rd_en    = !sts.refused;
        cmd.rd_first = !sts.refused;
      end
      S_SCAN: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_addr = cnt;
      end
      S_FINISH: begin
        cmd.commit = !sts.out_busy;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req_valid) state <= S_EVAL;
        end
        S_EVAL: begin
          if (sts.refused) begin
            state <= S_FINISH;
          end else if (sts.last_idx == '0) begin
            state <= S_DRAIN;
          end else begin
            cnt   <= WIN_IDX_W'(1);
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (cnt == sts.last_idx) begin
            state <= S_DRAIN;
          end else begin
            cnt <= cnt + WIN_IDX_W'(1);
          end
        end
        S_DRAIN: begin
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (!sts.out_busy) state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_rd_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_en |-> cmd.rd_addr <= sts.last_idx)
    else $error("window read beyond windows in use");

  a_accept_eval: assert property (@(posedge clk) disable iff (rst)
    (req_valid && cmd.take) |=> state == S_EVAL)
    else $error("accepted request did not start evaluation");

  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> !sts.out_busy)
    else $error("result committed over a stalled result");

  a_scan_first: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_first |-> (state == S_EVAL && cmd.rd_addr == '0))
    else $error("scan started away from window zero");
`endif

endmodule

FILE: rtl/earliest_free_server_assign.sv
// Earliest-free window assignment. Each request carries an arrival time
// (hour, minute, second) and a service length in minutes; the block answers
// with one result per request: whether it was served, the window that took it,
// the wait in seconds and the running totals of waits and served customers.
// Requests later than close_time are refused and leave the free times and
// totals unchanged, though first_of_batch still applies to them. first_of_batch
// resets every window to the open_time current at that moment and clears both
// totals before the request is handled. Times and totals saturate. A served
// request passes to the output register through the evaluate state (checks
// the close time, reads window zero), the scan state (sweeps the rest of the
// windows in use at one free-time RAM read per cycle), the drain state
// (compares the last read) and the finish state (commits). A refused request
// goes from evaluate straight to finish. Requests are taken only when idle,
// after the previous commit; a new request is taken while the previous result
// waits in the output register, and its commit then holds until that result
// is taken. Configuration writes are taken in any cycle and must only come
// while the block is idle; an open_time write applies from the next batch
// start.
module earliest_free_server_assign (
  input  logic       clk,
  input  logic       rst,
  efsa_cfg_if.sink   cfg,
  efsa_req_if.sink   req,
  efsa_rsp_if.source rsp
);
  import efsa_pkg::*;

  efsa_cmd_t cmd;
  efsa_sts_t sts;

  // Sequence the scan: evaluate, sweep the windows, drain the read, commit.
  efsa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Hold configuration, free times, totals and the result register.
  efsa_datapath u_dp (
    .clk (clk),
    .rst (rst),
    .cfg (cfg),
    .req (req),
    .rsp (rsp),
    .cmd (cmd),
    .sts (sts)
  );

endmodule
